FILE: hdl/rlc_pkg.sv
// shared types and constants of the reference counted lru cache
`default_nettype none
package rlc_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int REF_BITS   = 16;
  localparam int HIT_BITS   = 32;
  localparam int CFG_BITS   = 5;
  localparam int REC_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam logic [REF_BITS-1:0] REF_MAX = '1;
  localparam logic [HIT_BITS-1:0] HIT_MAX = '1;
  localparam logic [CFG_BITS-1:0] MAX_UNPINNED_RESET = CFG_BITS'(16);

  typedef enum logic [1:0] {
    CMD_HAS     = 2'd0,
    CMD_FIND    = 2'd1,
    CMD_ADD     = 2'd2,
    CMD_RELEASE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_FULL      = 3'd3,
    ST_DUPLICATE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FIND,
    OP_RELEASE,
    OP_EVICT,
    OP_INSERT
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_ADD
  } state_t;

  // controller to every cell
  typedef struct packed {
    cell_op_t              op;
    logic                  evict_mode;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [REC_W-1:0]      oldest_r;
    logic                  drop_en;
    logic [REC_W-1:0]      drop_r;
    logic                  bump_en;
  } bcast_t;

  // fields of the selected cell, or-ed along the chain
  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] payload;
    logic [KEY_BITS-1:0]   key;
    logic [REF_BITS-1:0]   refs;
    logic [HIT_BITS-1:0]   hits;
    logic [REC_W-1:0]      recency;
  } gather_t;

endpackage
`default_nettype wire

FILE: hdl/rlc_if.sv
// request, response and configuration channel interfaces
`default_nettype none
interface rlc_req_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     cmd;
  logic [rlc_pkg::KEY_BITS-1:0]   key;
  logic [rlc_pkg::VALUE_BITS-1:0] value;
  modport source (output valid, cmd, key, value, input ready);
  modport sink (input valid, cmd, key, value, output ready);
endinterface

interface rlc_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [rlc_pkg::VALUE_BITS-1:0] data;
  logic [rlc_pkg::REF_BITS-1:0]   ref_count;
  logic [rlc_pkg::HIT_BITS-1:0]   hit_count;
  logic [2:0]                     status;
  logic                           evicted;
  logic [rlc_pkg::KEY_BITS-1:0]   evicted_key;
  logic                           last;
  modport source (output valid, found, data, ref_count, hit_count, status, evicted,
                  evicted_key, last, input ready);
  modport sink (input valid, found, data, ref_count, hit_count, status, evicted,
                evicted_key, last, output ready);
endinterface

interface rlc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rlc_pkg::CFG_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/rlc_cell.sv
// one cache slot: key match, recency keeping and its link of the chain
`default_nettype none
module rlc_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rlc_pkg::bcast_t  bc,
  input  wire rlc_pkg::gather_t gather_in,
  output rlc_pkg::gather_t      gather_out,
  input  wire logic             free_in,
  output logic                  free_out
);

  logic                           valid;
  logic [rlc_pkg::KEY_BITS-1:0]   key;
  logic [rlc_pkg::VALUE_BITS-1:0] payload;
  logic [rlc_pkg::REF_BITS-1:0]   refs;
  logic [rlc_pkg::HIT_BITS-1:0]   hits;
  logic [rlc_pkg::REC_W-1:0]      recency;
  logic                           sel;
  logic                           unpinned;
  logic                           grab;

  assign unpinned = valid && (refs == '0);
  assign sel = valid && (bc.evict_mode ? (unpinned && (recency == bc.oldest_r))
                                       : (key == bc.key));
  assign grab     = free_in && !valid;
  assign free_out = free_in && valid;

  always_comb begin
    gather_out.hit     = gather_in.hit | sel;
    gather_out.payload = gather_in.payload | (sel ? payload : '0);
    gather_out.key     = gather_in.key | (sel ? key : '0);
    gather_out.refs    = gather_in.refs | (sel ? refs : '0);
    gather_out.hits    = gather_in.hits | (sel ? hits : '0);
    gather_out.recency = gather_in.recency | (sel ? recency : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      refs    <= '0;
      hits    <= '0;
      recency <= '0;
    end else begin
      unique case (bc.op)
        rlc_pkg::OP_FIND: begin
          if (sel) begin
            if (hits != rlc_pkg::HIT_MAX) hits <= hits + 1'b1;
            if (refs == '0) refs <= rlc_pkg::REF_BITS'(1);
            else if (refs != rlc_pkg::REF_MAX) refs <= refs + 1'b1;
          end else if (bc.drop_en && unpinned && (recency > bc.drop_r)) begin
            recency <= recency - 1'b1;
          end
        end
        rlc_pkg::OP_RELEASE: begin
          if (sel) begin
            refs <= refs - 1'b1;
            if (refs == rlc_pkg::REF_BITS'(1)) recency <= '0;
          end else if (bc.bump_en && unpinned) begin
            recency <= recency + 1'b1;
          end
        end
        rlc_pkg::OP_EVICT: begin
          if (sel) begin
            valid   <= 1'b0;
            refs    <= '0;
            hits    <= '0;
            recency <= '0;
          end
        end
        rlc_pkg::OP_INSERT: begin
          if (grab) begin
            valid   <= 1'b1;
            key     <= bc.key;
            payload <= bc.value;
            refs    <= '0;
            hits    <= '0;
            recency <= '0;
          end else if (unpinned) begin
            recency <= recency + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/rlc_ctrl.sv
// command sequencer, unpinned count, config register and response register
`default_nettype none
module rlc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  rlc_req_if.sink               req,
  rlc_rsp_if.source             rsp,
  rlc_cfg_if.sink               cfg,
  output rlc_pkg::bcast_t       bc,
  input  wire rlc_pkg::gather_t g,
  input  wire logic             no_free
);

  rlc_pkg::state_t                state;
  rlc_pkg::state_t                state_next;
  rlc_pkg::cmd_t                  cmd;
  logic [rlc_pkg::KEY_BITS-1:0]   key;
  logic [rlc_pkg::VALUE_BITS-1:0] value;
  logic [rlc_pkg::CFG_BITS-1:0]   max_unpinned;
  logic [rlc_pkg::CNT_W-1:0]      unpinned_count;
  logic [rlc_pkg::CNT_W-1:0]      unpinned_count_next;
  logic [rlc_pkg::CFG_BITS-1:0]   limit;
  logic                           emit_ok;
  logic                           load;
  logic                           need_evict;

  logic                           o_valid;
  logic                           o_found;
  logic [rlc_pkg::VALUE_BITS-1:0] o_data;
  logic [rlc_pkg::REF_BITS-1:0]   o_refs;
  logic [rlc_pkg::HIT_BITS-1:0]   o_hits;
  rlc_pkg::status_t               o_status;
  logic                           o_evicted;
  logic [rlc_pkg::KEY_BITS-1:0]   o_evkey;
  logic                           o_last;

  logic                           n_found;
  logic [rlc_pkg::VALUE_BITS-1:0] n_data;
  logic [rlc_pkg::REF_BITS-1:0]   n_refs;
  logic [rlc_pkg::HIT_BITS-1:0]   n_hits;
  rlc_pkg::status_t               n_status;
  logic                           n_evicted;
  logic [rlc_pkg::KEY_BITS-1:0]   n_evkey;
  logic                           n_last;

  assign req.ready = (state == rlc_pkg::S_IDLE);
  assign cfg.ready = 1'b1;
  assign emit_ok   = !o_valid || rsp.ready;
  assign limit     = (max_unpinned == '0) ? rlc_pkg::CFG_BITS'(1) : max_unpinned;
  assign need_evict = (unpinned_count != '0) &&
                      ((32'(unpinned_count) >= 32'(limit)) || no_free);

  always_ff @(posedge clk) begin
    if (rst) state <= rlc_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next          = state;
    unpinned_count_next = unpinned_count;
    load                = 1'b0;
    bc.op               = rlc_pkg::OP_NONE;
    bc.evict_mode       = (state == rlc_pkg::S_ADD);
    bc.key              = key;
    bc.value            = value;
    bc.oldest_r         = rlc_pkg::REC_W'(unpinned_count - 1'b1);
    bc.drop_en          = 1'b0;
    bc.drop_r           = g.recency;
    bc.bump_en          = 1'b0;
    n_found             = 1'b0;
    n_data              = '0;
    n_refs              = '0;
    n_hits              = '0;
    n_status            = rlc_pkg::ST_OK;
    n_evicted           = 1'b0;
    n_evkey             = '0;
    n_last              = 1'b1;
    unique case (state)
      rlc_pkg::S_IDLE: begin
        if (req.valid) state_next = rlc_pkg::S_EXEC;
      end
      rlc_pkg::S_EXEC: begin
        if (emit_ok) begin
          unique case (cmd)
            rlc_pkg::CMD_HAS: begin
              load       = 1'b1;
              n_found    = g.hit;
              n_status   = g.hit ? rlc_pkg::ST_OK : rlc_pkg::ST_NOT_FOUND;
              state_next = rlc_pkg::S_IDLE;
            end
            rlc_pkg::CMD_FIND: begin
              load       = 1'b1;
              state_next = rlc_pkg::S_IDLE;
              if (!g.hit) begin
                n_status = rlc_pkg::ST_NOT_FOUND;
              end else begin
                bc.op   = rlc_pkg::OP_FIND;
                n_found = 1'b1;
                n_data  = g.payload;
                n_hits  = (g.hits != rlc_pkg::HIT_MAX) ? g.hits + 1'b1 : g.hits;
                if (g.refs == '0) begin
                  n_refs     = rlc_pkg::REF_BITS'(1);
                  bc.drop_en = 1'b1;
                  if (unpinned_count != '0) unpinned_count_next = unpinned_count - 1'b1;
                end else begin
                  n_refs = (g.refs != rlc_pkg::REF_MAX) ? g.refs + 1'b1 : g.refs;
                end
              end
            end
            rlc_pkg::CMD_RELEASE: begin
              load       = 1'b1;
              state_next = rlc_pkg::S_IDLE;
              if (!g.hit) begin
                n_status = rlc_pkg::ST_NOT_FOUND;
              end else begin
                n_found = 1'b1;
                n_data  = g.payload;
                n_hits  = g.hits;
                if (g.refs == '0) begin
                  n_status = rlc_pkg::ST_UNDERFLOW;
                end else begin
                  bc.op  = rlc_pkg::OP_RELEASE;
                  n_refs = g.refs - 1'b1;
                  if (g.refs == rlc_pkg::REF_BITS'(1)) begin
                    bc.bump_en          = 1'b1;
                    unpinned_count_next = unpinned_count + 1'b1;
                  end
                end
              end
            end
            default: begin
              if (g.hit) begin
                load       = 1'b1;
                n_found    = 1'b1;
                n_data     = g.payload;
                n_refs     = g.refs;
                n_hits     = g.hits;
                n_status   = rlc_pkg::ST_DUPLICATE;
                state_next = rlc_pkg::S_IDLE;
              end else begin
                state_next = rlc_pkg::S_ADD;
              end
            end
          endcase
        end
      end
      rlc_pkg::S_ADD: begin
        if (emit_ok) begin
          load = 1'b1;
          if (need_evict) begin
            // the oldest unpinned entry holds recency count-1
            bc.op               = rlc_pkg::OP_EVICT;
            n_data              = g.payload;
            n_refs              = g.refs;
            n_hits              = g.hits;
            n_evicted           = 1'b1;
            n_evkey             = g.key;
            n_last              = 1'b0;
            unpinned_count_next = unpinned_count - 1'b1;
          end else if (no_free) begin
            n_status   = rlc_pkg::ST_FULL;
            state_next = rlc_pkg::S_IDLE;
          end else begin
            bc.op               = rlc_pkg::OP_INSERT;
            n_data              = value;
            unpinned_count_next = unpinned_count + 1'b1;
            state_next          = rlc_pkg::S_IDLE;
          end
        end
      end
      default: state_next = rlc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unpinned_count <= '0;
      max_unpinned   <= rlc_pkg::MAX_UNPINNED_RESET;
      o_valid        <= 1'b0;
    end else begin
      unpinned_count <= unpinned_count_next;
      if (cfg.valid) max_unpinned <= cfg.data;
      if (load) o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd   <= rlc_pkg::cmd_t'(req.cmd);
      key   <= req.key;
      value <= req.value;
    end
    if (load) begin
      o_found   <= n_found;
      o_data    <= n_data;
      o_refs    <= n_refs;
      o_hits    <= n_hits;
      o_status  <= n_status;
      o_evicted <= n_evicted;
      o_evkey   <= n_evkey;
      o_last    <= n_last;
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.found       = o_found;
  assign rsp.data        = o_data;
  assign rsp.ref_count   = o_refs;
  assign rsp.hit_count   = o_hits;
  assign rsp.status      = o_status;
  assign rsp.evicted     = o_evicted;
  assign rsp.evicted_key = o_evkey;
  assign rsp.last        = o_last;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(unpinned_count) <= rlc_pkg::CAPACITY)
    else $error("unpinned count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == rlc_pkg::S_EXEC))
    else $error("accepted request did not start");

  a_evict_count: assert property (@(posedge clk) disable iff (rst)
    (bc.op == rlc_pkg::OP_EVICT) |=> (unpinned_count == $past(unpinned_count) - 1'b1))
    else $error("eviction did not lower unpinned count");

  a_evict_hit: assert property (@(posedge clk) disable iff (rst)
    (bc.op == rlc_pkg::OP_EVICT) |-> g.hit)
    else $error("eviction without an oldest entry");
`endif

endmodule
`default_nettype wire

FILE: hdl/refcounted_lru_cache.sv
// Reference counted LRU cache: a row of slot cells driven by one sequencer.
// Channels: req (cmd, key, value) in, rsp (found, data, ref_count,
// hit_count, status, evicted, evicted_key, last) out, cfg writes
// max_unpinned and is always ready. All use valid/ready; a request is taken
// when both are high. Each request gives one or more responses, the final
// one with last set; an add first gives one response per evicted entry.
// Timing: a request is taken in the idle state and run in the exec state;
// an add then goes on in the add state with one eviction per cycle, while
// rsp does not stall, through the recency order. Responses are registered;
// the key match over all cells is combinational.
// The next request is taken while the last response still waits in the
// output register. If rsp stalls, the sequencer holds and nothing is lost.
// Reset clears every slot, the unpinned count and sets max_unpinned to 16;
// there is no clearing pass.
`default_nettype none
module refcounted_lru_cache (
  input  wire logic clk,
  input  wire logic rst,
  rlc_req_if.sink   req,
  rlc_rsp_if.source rsp,
  rlc_cfg_if.sink   cfg
);

  rlc_pkg::bcast_t  bc;
  rlc_pkg::gather_t gather [rlc_pkg::CAPACITY+1];
  logic             free_chain [rlc_pkg::CAPACITY+1];

  assign gather[0]     = '0;
  assign free_chain[0] = 1'b1;

  for (genvar i = 0; i < rlc_pkg::CAPACITY; i++) begin : g_cell
    rlc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .bc         (bc),
      .gather_in  (gather[i]),
      .gather_out (gather[i+1]),
      .free_in    (free_chain[i]),
      .free_out   (free_chain[i+1])
    );
  end

  rlc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .cfg     (cfg),
    .bc      (bc),
    .g       (gather[rlc_pkg::CAPACITY]),
    .no_free (free_chain[rlc_pkg::CAPACITY])
  );

endmodule
`default_nettype wire
